// ----- rtl/rkrd_pkg.sv -----
`timescale 1ns / 1ps

package rkrd_pkg;

   // Geometry of the key matrix
   localparam int STATIONS         = 15;
   localparam int KEYS_PER_STATION = 32;
   localparam int COUNT_LIMIT      = 100;

   // Key code arithmetic
   localparam int CODE_STEP = 100;
   localparam int CODE_W    = 11;
   localparam int CNT_W     = 7;
   localparam int RAIN_W    = 16;
   localparam int NIB_W     = 4;

   localparam int KEY_IDX_W = (KEYS_PER_STATION > 1) ? $clog2(KEYS_PER_STATION) : 1;
   localparam int ST_IDX_W  = (STATIONS > 1) ? $clog2(STATIONS) : 1;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int Q_PTR_W     = 1;
   localparam int Q_CNT_W     = 2;

   typedef struct packed {
      logic [7:0]  frame_id;
      logic [31:0] key_bits;
   } req_type;

   typedef struct packed {
      logic              key_valid;
      logic [CODE_W-1:0] key_code;
      logic              rain_flag;
      logic              last;
   } rsp_type;

   // One classified frame: code base, released keys, rain flag after the frame
   typedef struct packed {
      logic [CODE_W-1:0]           base;
      logic [KEYS_PER_STATION-1:0] mask;
      logic                        rain;
   } job_type;

   typedef logic [KEYS_PER_STATION-1:0][CNT_W-1:0] row_type;

endpackage

// ----- rtl/rkrd_front.sv -----
`timescale 1ns / 1ps

module rkrd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [rkrd_pkg::RAIN_W-1:0]   csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  rkrd_pkg::req_type             req_payload,
   output logic                          push_valid,
   input  logic                          push_ready,
   output rkrd_pkg::job_type             push_data
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WORK = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [rkrd_pkg::RAIN_W-1:0] rain_code_ff;
   logic                        rain_ff, rain_in;

   logic [rkrd_pkg::NIB_W-1:0]            nib_ff;
   logic [rkrd_pkg::KEYS_PER_STATION-1:0] bits_ff;
   logic                                  ok_ff;
   logic [rkrd_pkg::ST_IDX_W-1:0]         st_ff;

   rkrd_pkg::row_type mem [rkrd_pkg::STATIONS];
   logic [rkrd_pkg::STATIONS-1:0] row_valid_ff;
   rkrd_pkg::row_type             rd_row_ff;
   logic                          rd_valid_ff;

   logic                          req_fire, push_fire;
   logic [rkrd_pkg::NIB_W-1:0]    req_nib, req_nib_m1;
   logic                          req_ok;
   logic [rkrd_pkg::ST_IDX_W-1:0] req_st;

   logic [rkrd_pkg::CODE_W-1:0]           base;
   logic [rkrd_pkg::RAIN_W-1:0]           rain_diff;
   logic                                  rain_hit;
   logic [rkrd_pkg::KEY_IDX_W-1:0]        rain_idx;
   rkrd_pkg::row_type                     new_row;
   logic [rkrd_pkg::KEYS_PER_STATION-1:0] rel_mask;

   // Decode the incoming request
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign req_nib    = req_payload.frame_id[7:4];
   assign req_nib_m1 = req_nib - rkrd_pkg::NIB_W'(1);
   assign req_ok     = (req_nib != '0) && (req_nib <= rkrd_pkg::NIB_W'(rkrd_pkg::STATIONS));
   assign req_st     = req_nib_m1[rkrd_pkg::ST_IDX_W-1:0];

   // Locate the rain key within this station
   always_comb begin
      base      = rkrd_pkg::CODE_W'(nib_ff) * rkrd_pkg::CODE_W'(rkrd_pkg::CODE_STEP);
      rain_diff = rain_code_ff - rkrd_pkg::RAIN_W'(base) - rkrd_pkg::RAIN_W'(1);
      rain_hit  = ok_ff && (rain_code_ff > rkrd_pkg::RAIN_W'(base)) &&
                  (rain_diff < rkrd_pkg::RAIN_W'(rkrd_pkg::KEYS_PER_STATION));
      rain_idx  = rain_diff[rkrd_pkg::KEY_IDX_W-1:0];
   end

   // Update the counters of the row, all but the rain key's, and collect released keys
   always_comb begin
      logic [rkrd_pkg::CNT_W-1:0] old_cnt;
      old_cnt  = '0;
      new_row  = rd_row_ff;
      rel_mask = '0;
      for (int k = 0; k < rkrd_pkg::KEYS_PER_STATION; k++) begin
         old_cnt    = rd_valid_ff ? rd_row_ff[k] : '0;
         new_row[k] = old_cnt;
         if (!(rain_hit && (rain_idx == rkrd_pkg::KEY_IDX_W'(k)))) begin
            if (bits_ff[k]) begin
               if (old_cnt < rkrd_pkg::CNT_W'(rkrd_pkg::COUNT_LIMIT)) begin
                  new_row[k] = old_cnt + rkrd_pkg::CNT_W'(1);
               end
            end else begin
               rel_mask[k] = ok_ff && (old_cnt > rkrd_pkg::CNT_W'(1));
               new_row[k]  = '0;
            end
         end
      end
   end

   assign rain_in = rain_hit ? bits_ff[rain_idx] : rain_ff;

   // Hand the classified frame to the queue
   assign push_valid     = (state_ff == ST_WORK);
   assign push_fire      = push_valid && push_ready;
   assign push_data.base = base;
   assign push_data.mask = rel_mask;
   assign push_data.rain = rain_in;

   // Sequence accept and update
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_fire) state_in = ST_WORK;
         ST_WORK: if (push_fire) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rain_code_ff <= '0;
         rain_ff      <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) rain_code_ff <= csr_wr_data;
         if (push_fire) begin
            rain_ff <= rain_in;
            if (ok_ff) row_valid_ff[st_ff] <= 1'b1;
         end
      end
   end

   // Latch the request and read its row
   always_ff @(posedge clock) begin
      if (req_fire) begin
         nib_ff  <= req_nib;
         bits_ff <= req_payload.key_bits[rkrd_pkg::KEYS_PER_STATION-1:0];
         ok_ff   <= req_ok;
         st_ff   <= req_st;
         if (req_ok) begin
            rd_row_ff   <= mem[req_st];
            rd_valid_ff <= row_valid_ff[req_st];
         end else begin
            rd_valid_ff <= 1'b0;
         end
      end
   end

   // Write the updated row back
   always_ff @(posedge clock) begin
      if (push_fire && ok_ff) mem[st_ff] <= new_row;
   end

endmodule

// ----- rtl/rkrd_queue.sv -----
`timescale 1ns / 1ps

module rkrd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  rkrd_pkg::job_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output rkrd_pkg::job_type pop_data
);

   rkrd_pkg::job_type entry_ff [rkrd_pkg::QUEUE_DEPTH];
   logic [rkrd_pkg::Q_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [rkrd_pkg::Q_CNT_W-1:0] count_ff;
   logic push_fire, pop_fire;

   assign push_ready = (count_ff != rkrd_pkg::Q_CNT_W'(rkrd_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_fire) wr_ptr_ff <= wr_ptr_ff + rkrd_pkg::Q_PTR_W'(1);
         if (pop_fire)  rd_ptr_ff <= rd_ptr_ff + rkrd_pkg::Q_PTR_W'(1);
         if (push_fire && !pop_fire)      count_ff <= count_ff + rkrd_pkg::Q_CNT_W'(1);
         else if (pop_fire && !push_fire) count_ff <= count_ff - rkrd_pkg::Q_CNT_W'(1);
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (push_fire) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ----- rtl/rkrd_back.sv -----
`timescale 1ns / 1ps

module rkrd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  rkrd_pkg::job_type pop_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rkrd_pkg::rsp_type rsp_payload
);

   logic              active_ff;
   rkrd_pkg::job_type job_ff;
   logic              rsp_valid_ff;
   rkrd_pkg::rsp_type rsp_ff, rsp_in;

   logic                                  advance;
   logic [rkrd_pkg::KEY_IDX_W-1:0]        low_idx;
   logic [rkrd_pkg::KEYS_PER_STATION-1:0] remaining;

   assign pop_ready   = !active_ff;
   assign advance     = active_ff && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Pick the lowest released key
   always_comb begin
      low_idx = '0;
      for (int k = rkrd_pkg::KEYS_PER_STATION - 1; k >= 0; k--) begin
         if (job_ff.mask[k]) low_idx = rkrd_pkg::KEY_IDX_W'(k);
      end
      remaining = job_ff.mask & ~(rkrd_pkg::KEYS_PER_STATION'(1) << low_idx);
   end

   // Form the next result
   always_comb begin
      rsp_in.rain_flag = job_ff.rain;
      if (job_ff.mask == '0) begin
         rsp_in.key_valid = 1'b0;
         rsp_in.key_code  = '0;
         rsp_in.last      = 1'b1;
      end else begin
         rsp_in.key_valid = 1'b1;
         rsp_in.key_code  = job_ff.base + rkrd_pkg::CODE_W'(low_idx) + rkrd_pkg::CODE_W'(1);
         rsp_in.last      = (remaining == '0);
      end
   end

   // Load jobs, step through keys, hold the output until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!active_ff && pop_valid) begin
            active_ff <= 1'b1;
         end else if (advance && rsp_in.last) begin
            active_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!active_ff && pop_valid) begin
         job_ff <= pop_data;
      end else if (advance) begin
         job_ff.mask <= remaining;
      end
      if (advance) rsp_ff <= rsp_in;
   end

endmodule

// ----- rtl/remote_key_release_detector_unit.sv -----
`timescale 1ns / 1ps

// Remote key release detector.
// Request channel (req_valid/req_ready/req_payload) takes one key frame:
// frame_id and a 32-bit key mask. Response channel (rsp_valid/rsp_ready/
// rsp_payload) gives one result per released key, lowest bit first, or a
// single result with key_valid low when nothing fires; last marks the final
// result of a frame. csr_wr_en/csr_wr_data set the rain key code.
// Timing: the front takes a request, registers the station's counter row
// with it and writes the row back while it pushes the frame into a two-entry
// queue, so it takes no new request until that frame is pushed. The back
// loads a frame, then emits one result per cycle while the receiver takes
// them. Row memory port and the back's key scan set the rate.
// Reset clears the per-station row valid bits at once, so all counters read
// zero with no clearing pass; rain flag and rain key code go to zero.
// When the receiver stalls, the result holds in the output register, the
// queue fills, and then req_ready stays low.
module remote_key_release_detector_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [rkrd_pkg::RAIN_W-1:0] csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  rkrd_pkg::req_type           req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output rkrd_pkg::rsp_type           rsp_payload
);

   logic              push_valid, push_ready, pop_valid, pop_ready;
   rkrd_pkg::job_type push_data, pop_data;

   rkrd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   rkrd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   rkrd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   localparam int LONG_HOLD = 300;   // receiver hold-off, in cycles
   localparam int SETTLE    = 8;     // quiet cycles after the last result

   // Mirror of the key counters and the rain flag; holds the results still owed
   class key_event_board;
      logic [rkrd_pkg::CNT_W-1:0]  press_cnt [rkrd_pkg::STATIONS*rkrd_pkg::KEYS_PER_STATION];
      logic                        rain_now;
      logic [rkrd_pkg::RAIN_W-1:0] rain_code;
      rkrd_pkg::rsp_type           owed_q [$];
      int                          errors;
      int                          frames;
      int                          key_events;
      int                          empty_results;

      function new();
         foreach (press_cnt[i]) press_cnt[i] = '0;
         rain_now      = 1'b0;
         rain_code     = '0;
         errors        = 0;
         frames        = 0;
         key_events    = 0;
         empty_results = 0;
      endfunction

      // Work out the results of one accepted request and queue them
      function void note_frame(rkrd_pkg::req_type f);
         int unsigned                 nib;
         int unsigned                 st;
         int unsigned                 code;
         int unsigned                 idx;
         logic                        pressed;
         logic [rkrd_pkg::CODE_W-1:0] fired [$];
         rkrd_pkg::rsp_type           r;
         nib = f.frame_id[7:4];
         frames++;
         if (nib != 0 && nib - 1 < rkrd_pkg::STATIONS) begin
            st = nib - 1;
            for (int k = 0; k < rkrd_pkg::KEYS_PER_STATION && k < 32; k++) begin
               code    = (st + 1) * rkrd_pkg::CODE_STEP + k + 1;
               pressed = f.key_bits[k];
               idx     = st * rkrd_pkg::KEYS_PER_STATION + k;
               // rain key bypasses its counter
               if (code == rain_code) begin
                  rain_now = pressed;
                  continue;
               end
               if (pressed) begin
                  if (press_cnt[idx] < rkrd_pkg::COUNT_LIMIT) begin
                     press_cnt[idx] = press_cnt[idx] + 1'b1;
                  end
               end else begin
                  if (press_cnt[idx] > 1) fired.push_back(code[rkrd_pkg::CODE_W-1:0]);
                  press_cnt[idx] = '0;
               end
            end
         end
         if (fired.size() == 0) begin
            r.key_valid = 1'b0;
            r.key_code  = '0;
            r.rain_flag = rain_now;
            r.last      = 1'b1;
            owed_q.push_back(r);
         end else begin
            foreach (fired[i]) begin
               r.key_valid = 1'b1;
               r.key_code  = fired[i];
               r.rain_flag = rain_now;
               r.last      = (i == fired.size() - 1);
               owed_q.push_back(r);
            end
         end
      endfunction

      function void check_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      // Compare one accepted result with the oldest one owed
      function void check_result(rkrd_pkg::rsp_type got);
         rkrd_pkg::rsp_type want;
         if (owed_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            return;
         end
         want = owed_q.pop_front();
         check_field("key_valid", want.key_valid, got.key_valid);
         check_field("key_code", want.key_code, got.key_code);
         check_field("rain_flag", want.rain_flag, got.rain_flag);
         check_field("last", want.last, got.last);
         if (want.key_valid) key_events++;
         else empty_results++;
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        csr_wr_en;
   logic [rkrd_pkg::RAIN_W-1:0] csr_wr_data;
   logic                        req_valid;
   logic                        req_ready;
   rkrd_pkg::req_type           req_payload;
   logic                        rsp_valid;
   logic                        rsp_ready;
   rkrd_pkg::rsp_type           rsp_payload;

   key_event_board board = new();
   bit                quiet    = 1'b0;   // no idling on either side
   bit                hold_off = 1'b0;   // ask the receiver for a long stall
   logic [31:0]       held [16];         // key state per station nibble

   remote_key_release_detector_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   // Watch both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_frame(req_payload);
         if (rsp_valid && rsp_ready) board.check_result(rsp_payload);
      end
   end

   // Drive rsp_ready: random stall bursts, one long hold-off on request
   initial begin : receiver
      int n;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            hold_off = 1'b0;
            rsp_ready <= 1'b0;
            for (n = 1; n < LONG_HOLD; n++) @(posedge clock);
         end else if (quiet || $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            n = $urandom_range(1, 16);
            repeat (n - 1) @(posedge clock);
         end
      end
   end

   // Offer one request, maybe after an idle burst, and hold it until taken
   task automatic send_frame(input logic [7:0] id, input logic [31:0] bits);
      rkrd_pkg::req_type f;
      f.frame_id = id;
      f.key_bits = bits;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= f;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every owed result has arrived
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.owed_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_rain_code(input logic [rkrd_pkg::RAIN_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.rain_code = v;
   endtask

   // Evolve held keys per station; optionally pin one key of station 2 down
   task automatic run_random(input int count, input bit pin_key);
      int unsigned nib;
      logic [7:0]  id;
      for (int i = 0; i < count; i++) begin
         if (pin_key && i == 20) hold_off = 1'b1;
         if (pin_key && $urandom_range(0, 7) != 0) nib = 2;
         else nib = $urandom_range(0, 15);
         if ($urandom_range(0, 7) == 0) held[nib] = $urandom;
         else held[nib] = held[nib] ^ ($urandom & $urandom & $urandom);
         if (pin_key && nib == 2) held[2][31] = 1'b1;
         id[7:4] = nib[3:0];
         id[3:0] = $urandom_range(0, 15);
         send_frame(id, held[nib]);
      end
   endtask

   initial begin
      foreach (held[i]) held[i] = '0;
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      req_valid   <= 1'b0;
      req_payload <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Ignored nibble, single-frame press, full releases at both station ends
      send_frame(8'h0F, 32'hFFFF_FFFF);
      send_frame(8'h10, 32'hFFFF_FFFF);
      send_frame(8'h10, 32'h0000_0000);
      send_frame(8'h1A, 32'hFFFF_FFFF);
      send_frame(8'h1B, 32'hFFFF_FFFF);
      send_frame(8'h15, 32'h0000_0000);
      send_frame(8'hFF, 32'hFFFF_FFFF);
      send_frame(8'hF3, 32'hFFFF_FFFF);
      send_frame(8'hF0, 32'h0000_0000);
      send_frame(8'h30, 32'h8000_0001);
      send_frame(8'h37, 32'h8000_0001);
      send_frame(8'h3C, 32'h8000_0001);
      send_frame(8'h31, 32'h0000_0001);
      send_frame(8'h30, 32'h0000_0000);
      wait_idle();

      // Rain key inside station 2: flag follows its bit, no event from it
      write_rain_code(16'd205);
      send_frame(8'h20, 32'h0000_0011);
      send_frame(8'h20, 32'h0000_0011);
      send_frame(8'h20, 32'h0000_0000);
      send_frame(8'h20, 32'h0000_0010);
      send_frame(8'h1C, 32'h0000_0000);
      wait_idle();

      // Rain key out of every station's range: former rain bit counts again
      write_rain_code(16'hFFFF);
      send_frame(8'h25, 32'h0000_0010);
      send_frame(8'h25, 32'h0000_0010);
      send_frame(8'h25, 32'h0000_0000);
      wait_idle();

      // Long run on station 2 with one key pinned, past the saturation point
      write_rain_code(16'd210);
      run_random(160, 1'b1);
      wait_idle();

      write_rain_code(16'd1532);
      run_random(20, 1'b0);
      wait_idle();

      // Closing stretch with no idling
      write_rain_code(16'd101);
      quiet = 1'b1;
      run_random(20, 1'b0);
      wait_idle();

      $display("Covered %0d frames over six rain key settings with stalls and idling.",
               board.frames);
      $display("Checked %0d key events and %0d empty results.",
               board.key_events, board.empty_results);
      if (board.errors == 0 && board.owed_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Hard stop far beyond the slowest legal run
   initial begin
      #(10_000_000);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/rkrd_pkg.sv
rtl/rkrd_front.sv
rtl/rkrd_queue.sv
rtl/rkrd_back.sv
rtl/remote_key_release_detector_unit.sv
tb/testbench.sv
